/* rtl/reader_writer_lock_table_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the lock table
// Both macros sample on aclk of the module that uses them.
// ---------------------------------------------------------------------------
`ifndef READER_WRITER_LOCK_TABLE_MACROS_SVH
`define READER_WRITER_LOCK_TABLE_MACROS_SVH

// Check a property outside reset.
`define RWLT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on every edge, reset included.
`define RWLT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* rtl/rwlt_pkg.sv */
// ---------------------------------------------------------------------------
// rwlt_pkg
// Shared constants, codes and types of the reader/writer lock table.
// ---------------------------------------------------------------------------
`default_nettype none

package rwlt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int ID_W = 64;
    localparam int CNT_W = 8;

    localparam logic [CNT_W-1:0] WRITE_MARK = 8'hFF;
    localparam logic [CNT_W-1:0] READ_LIMIT = 8'hFE;

    localparam logic [1:0] OP_READ_ACQ  = 2'd0;
    localparam logic [1:0] OP_WRITE_ACQ = 2'd1;
    localparam logic [1:0] OP_READ_REL  = 2'd2;
    localparam logic [1:0] OP_WRITE_REL = 2'd3;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_HELD    = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic             spare_ok;
        logic [IDX_W-1:0] spare_idx;
    } lookup_t;

endpackage

`default_nettype wire

/* rtl/rwlt_lookup.sv */
// ---------------------------------------------------------------------------
// rwlt_lookup
// Associative search: lowest matching valid slot and lowest free slot.
// ---------------------------------------------------------------------------
`default_nettype none

module rwlt_lookup (
    input  wire logic [rwlt_pkg::TABLE_ENTRIES-1:0] slot_valid,
    input  wire logic [rwlt_pkg::ID_W-1:0]          slot_key [rwlt_pkg::TABLE_ENTRIES],
    input  wire logic [rwlt_pkg::ID_W-1:0]          lock_id,
    output rwlt_pkg::lookup_t                       result
);
    import rwlt_pkg::*;

    // Scan downward so the lowest index wins.
    always_comb begin
        result = '0;
        for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
            if (slot_valid[k] && (slot_key[k] == lock_id)) begin
                result.hit     = 1'b1;
                result.hit_idx = IDX_W'(k);
            end
            if (!slot_valid[k]) begin
                result.spare_ok  = 1'b1;
                result.spare_idx = IDX_W'(k);
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/reader_writer_lock_table.sv */
// ---------------------------------------------------------------------------
// reader_writer_lock_table
// Fully associative reader/writer lock table keyed by 64-bit ids.
// ---------------------------------------------------------------------------
//
//  channel   direction  tdata                               tuser
//  s_axis    in         [63:0] lock_id                      [1:0] opcode
//  m_axis    out        [0] granted, [2:1] status,          -
//                       [10:3] count_after, [15:11] zero
//
//  Each request word yields exactly one result word. A word waits in the
//  input register, where all slots are compared at once and the table is
//  updated; the result lands in the output register. Throughput is one
//  word per cycle while the output drains, set by the compare and update
//  of the slot array in one pass. Reset empties the table at once (no
//  clearing pass). A stalled output holds its word; the input register
//  keeps taking words as long as the output register can drain.
//
`default_nettype none

module reader_writer_lock_table (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request: tdata = lock_id; tuser = opcode
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,
    input  wire logic [1:0]  s_axis_tuser,
    // result: tdata = granted, status[1:0], count_after[7:0], zero pad
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata
);
    import rwlt_pkg::*;

    `include "reader_writer_lock_table_macros.svh"

    // Input register
    logic             in_valid_reg;
    logic [1:0]       in_op_reg;
    logic [ID_W-1:0]  in_id_reg;

    // Output register
    logic             out_valid_reg;
    logic             out_granted_reg;
    logic [1:0]       out_status_reg;
    logic [CNT_W-1:0] out_count_reg;

    // Lock table
    logic [TABLE_ENTRIES-1:0] slot_valid_reg;
    logic [ID_W-1:0]          slot_key_reg   [TABLE_ENTRIES];
    logic [CNT_W-1:0]         slot_count_reg [TABLE_ENTRIES];

    lookup_t          lk;
    logic             proc_fire;
    logic [CNT_W-1:0] hit_count;

    // Table update and result of the word in the input register
    logic             upd_set;     // write key, count and set valid
    logic             upd_count;   // write count only
    logic             upd_clr;     // free the slot
    logic [IDX_W-1:0] upd_idx;
    logic [CNT_W-1:0] upd_cnt;
    logic             res_granted;
    logic [1:0]       res_status;
    logic [CNT_W-1:0] res_count;

    // Terms watched by the assertions
    logic             out_stuck;
    logic             write_alloc;
    logic             state_clear;

    rwlt_lookup u_lookup (
        .slot_valid (slot_valid_reg),
        .slot_key   (slot_key_reg),
        .lock_id    (in_id_reg),
        .result     (lk)
    );

    // Process when the output register is empty or draining this cycle.
    assign proc_fire     = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || proc_fire;
    assign hit_count     = slot_count_reg[lk.hit_idx];

    always_comb begin
        upd_set     = 1'b0;
        upd_count   = 1'b0;
        upd_clr     = 1'b0;
        upd_idx     = lk.hit_idx;
        upd_cnt     = hit_count;
        res_granted = 1'b0;
        res_status  = ST_DONE;
        res_count   = '0;
        case (in_op_reg)
            OP_READ_ACQ, OP_WRITE_ACQ: begin
                if (lk.hit) begin
                    // Refuse a write on any entry, a read on a full or write-held one.
                    if ((in_op_reg == OP_WRITE_ACQ) || (hit_count >= READ_LIMIT)) begin
                        res_status = ST_HELD;
                        res_count  = hit_count;
                    end else begin
                        upd_count   = 1'b1;
                        upd_cnt     = hit_count + 8'd1;
                        res_granted = 1'b1;
                        res_count   = hit_count + 8'd1;
                    end
                end else if (!lk.spare_ok) begin
                    res_status = ST_FULL;
                end else begin
                    upd_set     = 1'b1;
                    upd_idx     = lk.spare_idx;
                    upd_cnt     = (in_op_reg == OP_WRITE_ACQ) ? WRITE_MARK : 8'd1;
                    res_granted = 1'b1;
                    res_count   = (in_op_reg == OP_WRITE_ACQ) ? WRITE_MARK : 8'd1;
                end
            end
            OP_READ_REL: begin
                if (!lk.hit) begin
                    res_status = ST_MISSING;
                end else if (hit_count <= 8'd1) begin
                    upd_clr     = 1'b1;
                    res_granted = 1'b1;
                end else begin
                    upd_count   = 1'b1;
                    upd_cnt     = hit_count - 8'd1;
                    res_granted = 1'b1;
                    res_count   = hit_count - 8'd1;
                end
            end
            default: begin
                if (!lk.hit) begin
                    res_status = ST_MISSING;
                end else begin
                    upd_clr     = 1'b1;
                    res_granted = 1'b1;
                end
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            slot_valid_reg <= '0;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (proc_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (proc_fire && upd_set) begin
                slot_valid_reg[upd_idx] <= 1'b1;
            end else if (proc_fire && upd_clr) begin
                slot_valid_reg[upd_idx] <= 1'b0;
            end
        end
    end

    // Payload: input word, result word and slot contents
    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_op_reg <= s_axis_tuser;
            in_id_reg <= s_axis_tdata;
        end
        if (proc_fire) begin
            out_granted_reg <= res_granted;
            out_status_reg  <= res_status;
            out_count_reg   <= res_count;
            if (upd_set) begin
                slot_key_reg[upd_idx] <= in_id_reg;
            end
            if (upd_set || upd_count) begin
                slot_count_reg[upd_idx] <= upd_cnt;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_count_reg, out_status_reg, out_granted_reg};

    assign out_stuck   = out_valid_reg && !m_axis_tready;
    assign write_alloc = proc_fire && (in_op_reg == OP_WRITE_ACQ) && !lk.hit && lk.spare_ok;
    assign state_clear = (slot_valid_reg == '0) && !out_valid_reg;

    // Input only backs up when the output word is stuck.
    `RWLT_ASSERT(a_ready_only_on_stall, !s_axis_tready |-> out_stuck, "input stalled early")
    // A granted write acquire leaves the write mark in the result.
    `RWLT_ASSERT(a_write_grant_mark, write_alloc |=> out_count_reg == WRITE_MARK, "no write mark")
    // Reset empties the table and the output register.
    `RWLT_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> state_clear, "reset left state behind")

endmodule

`default_nettype wire
